// ----- rtl/mlpf_pkg.sv -----
package mlpf_pkg;

    localparam int TOP_LEVEL_DEF   = 10;
    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int WORD_WIDTH_DEF  = 32;

    // Result codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Item codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

endpackage

// ----- rtl/mlpf_ram.sv -----
module mlpf_ram #(
    parameter  int WIDTH = mlpf_pkg::WORD_WIDTH_DEF,
    parameter  int DEPTH = (mlpf_pkg::TOP_LEVEL_DEF + 1) * mlpf_pkg::LEVEL_DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/multi_level_priority_fifo.sv -----
// Enqueue, and a dequeue that finds every level empty: the result beat is
// presented in the cycle after the input beat is accepted.
// Dequeue of a word: the entry RAM has a registered read, so the word goes from the RAM
// read register into the output register in S_READ, which holds off the input side.
// Throughput: one enqueue per cycle unless the output stalls; a word dequeue waits in S_READ.
// Reset (synchronous, active low) clears head, tail and count registers; the entry RAM is not.
module multi_level_priority_fifo #(
    parameter  int TOP_LEVEL   = mlpf_pkg::TOP_LEVEL_DEF,
    parameter  int LEVEL_DEPTH = mlpf_pkg::LEVEL_DEPTH_DEF,
    parameter  int WORD_WIDTH  = mlpf_pkg::WORD_WIDTH_DEF,
    localparam int NUM_LEVELS  = TOP_LEVEL + 1,
    localparam int LVL_IDX_W   = $clog2(NUM_LEVELS),
    localparam int LEVEL_W     = (LVL_IDX_W > 4) ? LVL_IDX_W : 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_action,
    input  logic        [LEVEL_W-1:0]    i_priority_req,
    input  logic signed [WORD_WIDTH-1:0] i_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic        [1:0]            o_status,
    output logic signed [WORD_WIDTH-1:0] o_word_out,
    output logic        [LEVEL_W-1:0]    o_level_out
);

    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int SLOTS  = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [PTR_W-1:0] r_head  [NUM_LEVELS];
    logic [PTR_W-1:0] r_tail  [NUM_LEVELS];
    logic [CNT_W-1:0] r_count [NUM_LEVELS];

    logic                         r_out_valid;
    mlpf_pkg::t_status            r_status;
    logic signed [WORD_WIDTH-1:0] r_word;
    logic [LEVEL_W-1:0]           r_level;
    logic [LVL_IDX_W-1:0]         r_deq_level;

    logic                  in_accept;
    logic                  is_enq;
    logic                  in_range;
    logic [LVL_IDX_W-1:0]  enq_idx;
    logic [CNT_W-1:0]      enq_cnt;
    logic [PTR_W-1:0]      enq_tail;
    logic                  enq_ok;
    logic                  any_busy;
    logic [LVL_IDX_W-1:0]  found;
    logic [PTR_W-1:0]      deq_head;
    logic                  deq_ok;
    logic                  ram_we;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WORD_WIDTH-1:0] ram_rdata;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Accept only in S_IDLE and when the output register will be free after this edge
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_accept  = i_in_valid && o_in_ready;
    assign is_enq     = (i_action == mlpf_pkg::ACT_ENQ);

    assign in_range = (i_priority_req <= LEVEL_W'(TOP_LEVEL));
    assign enq_idx  = i_priority_req[LVL_IDX_W-1:0];
    assign enq_cnt  = in_range ? r_count[enq_idx] : CNT_W'(LEVEL_DEPTH);
    assign enq_tail = in_range ? r_tail[enq_idx] : '0;
    assign enq_ok   = in_range && (enq_cnt < CNT_W'(LEVEL_DEPTH));

    // Highest non-empty level wins
    always_comb begin
        found    = '0;
        any_busy = 1'b0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (r_count[l] != '0) begin
                found    = LVL_IDX_W'(l);
                any_busy = 1'b1;
            end
        end
    end

    assign deq_head = r_head[found];
    assign deq_ok   = any_busy;

    assign ram_we    = in_accept && is_enq && enq_ok;
    assign ram_re    = in_accept && !is_enq && deq_ok;
    assign ram_waddr = ADDR_W'(enq_idx) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(enq_tail);
    assign ram_raddr = ADDR_W'(found) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(deq_head);

    mlpf_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ($unsigned(i_data)),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (ram_re) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_tail[enq_idx]  <= next_slot(enq_tail);
                r_count[enq_idx] <= enq_cnt + CNT_W'(1);
            end
            if (ram_re) begin
                r_head[found]  <= next_slot(deq_head);
                r_count[found] <= r_count[found] - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_READ) begin
            r_out_valid <= 1'b1;
        end else if (in_accept && !ram_re) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_deq_level <= found;
        end
        if (r_state == S_READ) begin
            r_status <= mlpf_pkg::ST_DONE;
            r_word   <= $signed(ram_rdata);
            r_level  <= LEVEL_W'(r_deq_level);
        end else if (in_accept && !ram_re) begin
            // Enqueue result, or dequeue of an empty queue
            if (is_enq) begin
                r_status <= enq_ok ? mlpf_pkg::ST_DONE : mlpf_pkg::ST_FULL;
            end else begin
                r_status <= mlpf_pkg::ST_EMPTY;
            end
            r_word  <= '0;
            r_level <= '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_word_out  = r_word;
    assign o_level_out = r_level;

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> !r_out_valid)
        else $error("output register busy while a dequeue read is in flight");

    a_deq_enters_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> r_state == S_READ && !o_in_ready)
        else $error("dequeue read did not hold the input side");

    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> r_out_valid && r_status == mlpf_pkg::ST_DONE)
        else $error("dequeue read did not produce a result beat");

    a_no_enq_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> enq_cnt < CNT_W'(LEVEL_DEPTH))
        else $error("write into a full level");

endmodule

// ----- verif/multi_level_priority_fifo_tb.sv -----
`timescale 1ns / 100ps

module multi_level_priority_fifo_tb;

    localparam int TOP_LEVEL   = mlpf_pkg::TOP_LEVEL_DEF;
    localparam int LEVEL_DEPTH = mlpf_pkg::LEVEL_DEPTH_DEF;
    localparam int WORD_WIDTH  = mlpf_pkg::WORD_WIDTH_DEF;
    localparam int NUM_LEVELS  = TOP_LEVEL + 1;
    localparam int MAX_PRI     = 15;
    localparam int MAX_GAP     = 12;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 50;

    typedef struct {
        mlpf_pkg::t_status            status;
        logic signed [WORD_WIDTH-1:0] word;
        logic [3:0]                   level;
    } t_queue_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic                         i_action = mlpf_pkg::ACT_ENQ;
    logic [3:0]                   i_priority_req = '0;
    logic signed [WORD_WIDTH-1:0] i_data = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [1:0]                   o_status;
    logic signed [WORD_WIDTH-1:0] o_word_out;
    logic [3:0]                   o_level_out;

    // queue state as seen by the predictor
    logic signed [WORD_WIDTH-1:0] lvl_words [NUM_LEVELS][LEVEL_DEPTH];
    int                           lvl_head  [NUM_LEVELS] = '{default: 0};
    int                           lvl_tail  [NUM_LEVELS] = '{default: 0};
    int                           lvl_count [NUM_LEVELS] = '{default: 0};

    t_queue_result pending_results[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    bit            tx_idle_on = 1'b1;
    bit            rx_idle_on = 1'b1;
    int            rx_hold_cycles = 0;

    multi_level_priority_fifo dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_priority_req (i_priority_req),
        .i_data         (i_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_word_out     (o_word_out),
        .o_level_out    (o_level_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("multi_level_priority_fifo_tb failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Apply one operation to the queue state and record the result it must give.
    function automatic void predict_queue_op(input logic act, input logic [3:0] lvl,
                                             input logic signed [WORD_WIDTH-1:0] word);
        t_queue_result res;
        int            top;
        int            l;
        res.status = mlpf_pkg::ST_DONE;
        res.word   = '0;
        res.level  = '0;
        if (act == mlpf_pkg::ACT_ENQ) begin
            if (lvl > TOP_LEVEL) begin
                res.status = mlpf_pkg::ST_FULL;
            end else if (lvl_count[lvl] >= LEVEL_DEPTH) begin
                res.status = mlpf_pkg::ST_FULL;
            end else begin
                lvl_words[lvl][lvl_tail[lvl]] = word;
                lvl_tail[lvl] = (lvl_tail[lvl] + 1) % LEVEL_DEPTH;
                lvl_count[lvl]++;
            end
        end else begin
            top = -1;
            for (l = TOP_LEVEL; l >= 0; l--)
                if (top < 0 && lvl_count[l] != 0) top = l;
            if (top < 0) begin
                res.status = mlpf_pkg::ST_EMPTY;
            end else begin
                res.word  = lvl_words[top][lvl_head[top]];
                res.level = 4'(top);
                lvl_head[top] = (lvl_head[top] + 1) % LEVEL_DEPTH;
                lvl_count[top]--;
            end
        end
        pending_results.push_back(res);
    endfunction

    // Valid stays high after a beat; the next call either changes the payload
    // or drops valid at the following falling edge.
    task automatic send_queue_op(input logic act, input logic [3:0] lvl,
                                 input logic signed [WORD_WIDTH-1:0] word);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_priority_req <= lvl;
        i_data         <= word;
        do @(posedge i_clk); while (!o_in_ready);
        predict_queue_op(act, lvl, word);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        t_queue_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", {30'd0, o_status}, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", {30'd0, o_status}, {30'd0, want.status});
                if (o_word_out !== want.word)
                    report_mismatch("word_out", o_word_out, want.word);
                if (o_level_out !== want.level)
                    report_mismatch("level_out", {28'd0, o_level_out}, {28'd0, want.level});
            end
        end
    end

    // Result side: random stalls per beat, plus one long hold when requested.
    initial begin : result_sink
        int gap;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (rx_hold_cycles > 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic test_extremes();
        send_queue_op(mlpf_pkg::ACT_DEQ, 4'd0, 32'sd0);
        send_queue_op(mlpf_pkg::ACT_ENQ, 4'd0, 32'sh8000_0000);
        send_queue_op(mlpf_pkg::ACT_ENQ, 4'(TOP_LEVEL), 32'sh7fff_ffff);
        send_queue_op(mlpf_pkg::ACT_ENQ, 4'(MAX_PRI), 32'sh5555_aaaa);
        send_queue_op(mlpf_pkg::ACT_ENQ, 4'(TOP_LEVEL + 1), -32'sd1);
        send_queue_op(mlpf_pkg::ACT_DEQ, 4'(MAX_PRI), -32'sd1);
        send_queue_op(mlpf_pkg::ACT_DEQ, 4'd8, 32'sh1234_5678);
        send_queue_op(mlpf_pkg::ACT_DEQ, 4'd0, 32'sd0);
    endtask

    // Overfill one level; the last enqueue must bounce.
    task automatic test_level_full();
        int n;
        for (n = 0; n <= LEVEL_DEPTH; n++)
            send_queue_op(mlpf_pkg::ACT_ENQ, 4'd4, $urandom);
    endtask

    // Hold the result side for a long stretch so the input side backs up.
    task automatic test_backpressure();
        int n;
        drain_results();
        tx_idle_on = 1'b0;
        rx_hold_cycles = 250;
        for (n = 0; n < 70; n++)
            send_queue_op(($urandom_range(0, 3) == 0) ? mlpf_pkg::ACT_DEQ : mlpf_pkg::ACT_ENQ,
                          4'($urandom_range(0, TOP_LEVEL)), $urandom);
        drain_results();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_pause();
        int n;
        for (n = 0; n < 60; n++) begin
            if (n == 30) drain_results();
            send_queue_op(1'($urandom_range(0, 1)), 4'($urandom_range(0, MAX_PRI)),
                          $urandom);
        end
    endtask

    task automatic test_random(input int total);
        int sent;
        int n;
        int mode;
        int base;
        int span;
        int deq_pct;
        int lvl;
        logic act;
        sent = 0;
        while (sent < total) begin
            mode = $urandom_range(0, 2);
            base = $urandom_range(0, TOP_LEVEL);
            span = $urandom_range(0, 2);
            deq_pct = (mode == 0) ? 15 : (mode == 1) ? 85 : 50;
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (n = 0; n < 50 && sent < total; n++) begin
                act = ($urandom_range(0, 99) < deq_pct) ? mlpf_pkg::ACT_DEQ
                                                        : mlpf_pkg::ACT_ENQ;
                if ($urandom_range(0, 19) == 0) begin
                    lvl = $urandom_range(TOP_LEVEL + 1, MAX_PRI);
                end else if (mode == 2) begin
                    lvl = $urandom_range(0, TOP_LEVEL);
                end else begin
                    // crowd a few neighboring levels so they reach full
                    lvl = base + $urandom_range(0, span);
                    if (lvl > TOP_LEVEL) lvl = TOP_LEVEL;
                end
                send_queue_op(act, 4'(lvl), $urandom);
                sent++;
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_level_full();
        test_backpressure();
        test_pause();
        test_random(1400);
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("multi_level_priority_fifo_tb passed");
        else
            $display("multi_level_priority_fifo_tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mlpf_pkg.sv
rtl/mlpf_ram.sv
rtl/multi_level_priority_fifo.sv
verif/multi_level_priority_fifo_tb.sv
